// File: rtl/mhg_pkg.sv
`default_nettype none

package mhg_pkg;

  // operating modes carried in the request tuser
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_NONE   = 2'd3
  } mhg_mode_t;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_ON  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_OFF = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HUM_ON   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HUM_OFF  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BOOT     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ON   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MIN_OFF  = 3'd6;

  localparam int CfgDataW = 32;
  localparam int TempW    = 15;
  localparam int HumW     = 14;
  localparam int TimeW    = 32;

  // stream widths
  localparam int InDataW  = 72;
  localparam int InUserW  = 2;
  localparam int OutDataW = 8;

  // reset values of the registers
  localparam logic signed [TempW-1:0] TEMP_ON_RST  = 15'sd3200;
  localparam logic signed [TempW-1:0] TEMP_OFF_RST = 15'sd2800;
  localparam logic [HumW-1:0]         HUM_ON_RST   = 14'd6000;
  localparam logic [HumW-1:0]         HUM_OFF_RST  = 14'd8000;
  localparam logic [TimeW-1:0]        BOOT_RST     = 32'd10000;
  localparam logic [TimeW-1:0]        MAX_ON_RST   = 32'd60000;
  localparam logic [TimeW-1:0]        MIN_OFF_RST  = 32'd30000;

  typedef struct packed {
    logic signed [TempW-1:0] temp_on_threshold;
    logic signed [TempW-1:0] temp_off_threshold;
    logic [HumW-1:0]         humidity_on_threshold;
    logic [HumW-1:0]         humidity_off_threshold;
    logic [TimeW-1:0]        boot_guard_time;
    logic [TimeW-1:0]        mist_max_on_time;
    logic [TimeW-1:0]        mist_min_off_time;
  } mhg_cfg_t;

  typedef struct packed {
    mhg_mode_t               mode;
    logic [TimeW-1:0]        now_ms;
    logic signed [TempW-1:0] temperature;
    logic                    temperature_ok;
    logic [HumW-1:0]         humidity;
    logic                    humidity_ok;
    logic                    manual_pump;
    logic                    manual_mist;
  } mhg_item_t;

  typedef struct packed {
    logic pump_on;
    logic mist_on;
  } mhg_result_t;

endpackage

`default_nettype wire

// File: rtl/mhg_cfg.sv
`default_nettype none

module mhg_cfg
  import mhg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output mhg_cfg_t                 cfg
);

  // register file, written one register per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_on_threshold      <= TEMP_ON_RST;
      cfg.temp_off_threshold     <= TEMP_OFF_RST;
      cfg.humidity_on_threshold  <= HUM_ON_RST;
      cfg.humidity_off_threshold <= HUM_OFF_RST;
      cfg.boot_guard_time        <= BOOT_RST;
      cfg.mist_max_on_time       <= MAX_ON_RST;
      cfg.mist_min_off_time      <= MIN_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_ON:  cfg.temp_on_threshold      <= signed'(cfg_data[TempW-1:0]);
        CFG_TEMP_OFF: cfg.temp_off_threshold     <= signed'(cfg_data[TempW-1:0]);
        CFG_HUM_ON:   cfg.humidity_on_threshold  <= cfg_data[HumW-1:0];
        CFG_HUM_OFF:  cfg.humidity_off_threshold <= cfg_data[HumW-1:0];
        CFG_BOOT:     cfg.boot_guard_time        <= cfg_data[TimeW-1:0];
        CFG_MAX_ON:   cfg.mist_max_on_time       <= cfg_data[TimeW-1:0];
        CFG_MIN_OFF:  cfg.mist_min_off_time      <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mhg_step.sv
`default_nettype none

module mhg_step
  import mhg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire mhg_item_t item,
  input  wire mhg_cfg_t  cfg,
  output mhg_result_t result
);

  // guard state
  logic             mist_previous;
  logic             mist_forced_off;
  logic             boot_guard_passed;
  logic [TimeW-1:0] boot_start_stamp;
  logic [TimeW-1:0] mist_on_stamp;
  logic [TimeW-1:0] mist_off_stamp;

  logic             mist_previous_next;
  logic             mist_forced_off_next;
  logic             boot_guard_passed_next;
  logic [TimeW-1:0] boot_start_stamp_next;
  logic [TimeW-1:0] mist_on_stamp_next;
  logic [TimeW-1:0] mist_off_stamp_next;

  logic             dry, hot, cool, humid;
  logic             want;
  logic [TimeW-1:0] boot_stamp_eff;
  logic [TimeW-1:0] boot_elapsed;
  logic             boot_ready;
  logic [TimeW-1:0] off_elapsed;
  logic             cooling;
  logic [TimeW-1:0] on_elapsed;
  logic             too_long;

  // sensor compares
  assign dry   = item.humidity <= cfg.humidity_on_threshold;
  assign humid = item.humidity >= cfg.humidity_off_threshold;
  assign hot   = item.temperature >= cfg.temp_on_threshold;
  assign cool  = item.temperature <= cfg.temp_off_threshold;

  // hysteresis decision, holding the last output inside the dead band
  always_comb begin
    want = 1'b0;
    if (item.temperature_ok && item.humidity_ok) begin
      if (dry && hot)        want = 1'b1;
      else if (cool || humid) want = 1'b0;
      else                   want = mist_previous;
    end else if (item.humidity_ok) begin
      if (dry)        want = 1'b1;
      else if (humid) want = 1'b0;
      else            want = mist_previous;
    end else if (item.temperature_ok) begin
      if (hot)       want = 1'b1;
      else if (cool) want = 1'b0;
      else           want = mist_previous;
    end
  end

  // boot guard: an unset stamp is taken from this tick
  assign boot_stamp_eff = (boot_start_stamp == '0) ? item.now_ms : boot_start_stamp;
  assign boot_elapsed   = item.now_ms - boot_stamp_eff;
  assign boot_ready     = boot_guard_passed || (boot_elapsed >= cfg.boot_guard_time);

  // cooldown and max-on timing, mist turning on restarts the on time
  assign off_elapsed = item.now_ms - mist_off_stamp;
  assign cooling     = mist_forced_off && (off_elapsed < cfg.mist_min_off_time);
  assign on_elapsed  = mist_previous ? (item.now_ms - mist_on_stamp) : '0;
  assign too_long    = on_elapsed >= cfg.mist_max_on_time;

  // next state and result
  always_comb begin
    result                 = '0;
    mist_forced_off_next   = mist_forced_off;
    boot_guard_passed_next = boot_guard_passed;
    boot_start_stamp_next  = boot_start_stamp;
    mist_on_stamp_next     = mist_on_stamp;
    mist_off_stamp_next    = mist_off_stamp;
    case (item.mode)
      MODE_IDLE: begin
        mist_forced_off_next   = 1'b0;
        boot_guard_passed_next = 1'b0;
        boot_start_stamp_next  = '0;
      end
      MODE_MANUAL: begin
        result.pump_on = item.manual_pump;
        result.mist_on = item.manual_mist;
      end
      MODE_AUTO: begin
        if (!boot_guard_passed) begin
          boot_start_stamp_next  = boot_stamp_eff;
          boot_guard_passed_next = boot_ready;
        end
        if (boot_ready && !cooling) begin
          mist_forced_off_next = 1'b0;
          if (want) begin
            if (!mist_previous) mist_on_stamp_next = item.now_ms;
            if (too_long) begin
              mist_forced_off_next = 1'b1;
              mist_off_stamp_next  = item.now_ms;
            end else begin
              result.mist_on = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    mist_previous_next = result.mist_on;
  end

  // state update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      mist_previous     <= 1'b0;
      mist_forced_off   <= 1'b0;
      boot_guard_passed <= 1'b0;
      boot_start_stamp  <= '0;
      mist_on_stamp     <= '0;
      mist_off_stamp    <= '0;
    end else if (advance) begin
      mist_previous     <= mist_previous_next;
      mist_forced_off   <= mist_forced_off_next;
      boot_guard_passed <= boot_guard_passed_next;
      boot_start_stamp  <= boot_start_stamp_next;
      mist_on_stamp     <= mist_on_stamp_next;
      mist_off_stamp    <= mist_off_stamp_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mist_hysteresis_guard_controller.sv
// a request is held in the input register, then its result in the result register
// throughput: one request per cycle while m_tready keeps up, set by the
//   single-pass step into the result register; state updates in that same cycle
// reset: synchronous active-high rst clears both stages, the guard state and
//   restores the default thresholds and times
`default_nettype none

module mist_hysteresis_guard_controller
  import mhg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // now_ms[31:0], temperature[46:32], temperature_ok[47], humidity[61:48],
  // humidity_ok[62], manual_pump[63], manual_mist[64], zero fill above
  input  wire logic [InDataW-1:0]  s_tdata,
  // mode[1:0]
  input  wire logic [InUserW-1:0]  s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // pump_on[0], mist_on[1], zero fill above
  output logic [OutDataW-1:0]      m_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  mhg_cfg_t    cfg;
  mhg_item_t   item;
  mhg_result_t result;
  logic        item_valid;
  logic        advance;
  logic        pump_on;
  logic        mist_on;

  // input stage moves on when the result register is free or being taken
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode           <= mhg_mode_t'(s_tuser);
      item.now_ms         <= s_tdata[31:0];
      item.temperature    <= signed'(s_tdata[46:32]);
      item.temperature_ok <= s_tdata[47];
      item.humidity       <= s_tdata[61:48];
      item.humidity_ok    <= s_tdata[62];
      item.manual_pump    <= s_tdata[63];
      item.manual_mist    <= s_tdata[64];
    end
  end

  mhg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mhg_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pump_on <= result.pump_on;
      mist_on <= result.mist_on;
    end
  end

  assign m_tdata = {{(OutDataW-2){1'b0}}, mist_on, pump_on};

  // checks
  a_auto_pump_off: assert property (@(posedge clk) disable iff (rst)
    advance && item.mode == MODE_AUTO |=> !m_tdata[0])
    else $error("pump driven in auto mode");

  a_idle_all_off: assert property (@(posedge clk) disable iff (rst)
    advance && (item.mode == MODE_IDLE || item.mode == MODE_NONE) |=> m_tdata[1:0] == 2'b00)
    else $error("output on in idle or unused mode");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
